// ===== sv/nnbd_pkg.sv =====
// Shared types and constants of the nearest-neighbor box downscaler.
// No dependencies; imported by nnbd_div and the top level (nnbd_ram needs none).
`timescale 1ns / 1ps
`default_nettype none

package nnbd_pkg;

    // Image and store geometry
    localparam int BOX_SIDE    = 120;
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LOAD_W      = $clog2(STORE_DEPTH + 1);

    // Field widths
    localparam int SIDE_W = 10;   // source side
    localparam int OUT_W  = 8;    // reduced side and position
    localparam int PIX_W  = 16;   // RGB565
    localparam int IDX_W  = 20;   // source index, up to 1023 * 1023
    localparam int ACC_W  = 9;    // error accumulator sum, below 2 * 255

    // Setup divider
    localparam int DIV_NUM_W = 18;  // 1023 * 255 fits
    localparam int DIV_DEN_W = 10;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'd1;

    // Request modes
    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] source_pixel;
    } request_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [OUT_W-1:0] out_col;
        logic [OUT_W-1:0] out_row;
        logic [OUT_W-1:0] out_width;
        logic [OUT_W-1:0] out_height;
        logic             last_pixel;
        logic             load_overflow;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/nnbd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nnbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/nnbd_div.sv =====
// Restoring divider, one quotient bit per cycle, used while sizes are set up.
// Depends on nnbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nnbd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [nnbd_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [nnbd_pkg::DIV_DEN_W-1:0] den,
    output logic      [nnbd_pkg::DIV_NUM_W-1:0] quo,
    output logic      [nnbd_pkg::DIV_DEN_W-1:0] rem,
    output logic                                done
);

    import nnbd_pkg::*;

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_sub  = rem_sh - {1'b0, den_reg};
        rem_next = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/nearest_neighbour_box_downscale.sv =====
// Top level of the nearest-neighbor box downscaler: pixel store, fetch walker
// and setup sequencer. Depends on nnbd_pkg, nnbd_ram and nnbd_div.
//
// Usage
//   A request transfers on a rising edge with start high and busy low.
//   mode = store writes source_pixel at the next raster address of the pixel
//   store (no result); once the store is full further stores are
//   dropped and load_overflow is set until the next restart.
//   mode = fetch returns the next pixel of the reduced image in raster order:
//   done is high for exactly one cycle, the cycle after the transfer, with
//   the result on the result port. A fetch waits for the registered store
//   read; busy is high while that read completes. After the last pixel
//   (last_pixel = 1) fetching wraps to row 0, column 0.
//   The receiver cannot stall: a result is valid only while done is high.
//   Register writes (wr_en, wr_index, wr_data) take effect at once, restart
//   loading and fetching (the store keeps its contents) and start a setup
//   pass: up to three divisions and one multiply, during which busy is high.
//   Back-to-back writes simply restart the pass.
//   Reset: source size 1 x 1, output size 1 x 1, counters cleared. The store
//   is not cleared; fetching entries never loaded returns undefined pixels.
//   Column and row source positions come from error accumulators, so a fetch
//   needs no division: one store read per pixel.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbour_box_downscale (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire nnbd_pkg::request_t             request,
    input  wire logic                           wr_en,
    input  wire logic [nnbd_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [nnbd_pkg::SIDE_W-1:0]    wr_data,
    output logic                                done,
    output nnbd_pkg::result_t                   result
);

    import nnbd_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_READ      = 9'b000000010,
        ST_SIZE_GO   = 9'b000000100,
        ST_SIZE_WAIT = 9'b000001000,
        ST_COL_GO    = 9'b000010000,
        ST_COL_WAIT  = 9'b000100000,
        ST_ROW_GO    = 9'b001000000,
        ST_ROW_WAIT  = 9'b010000000,
        ST_STEP      = 9'b100000000
    } state_t;

    state_t state_reg;

    // configuration and derived geometry
    logic [SIDE_W-1:0] src_w_reg, src_h_reg;
    logic [SIDE_W-1:0] w_eff, h_eff;
    logic [OUT_W-1:0]  nw_reg, nh_reg;
    logic [SIDE_W-1:0] qw_reg, qh_reg;    // integer part of step per column/row
    logic [OUT_W-1:0]  rw_reg, rh_reg;    // fractional part, in units of 1/nw, 1/nh
    logic [IDX_W-1:0]  step_lo_reg, step_hi_reg;  // qh*w and (qh+1)*w
    logic              scale;

    // walker state
    logic [LOAD_W-1:0] load_addr_reg;
    logic              overflow_reg;
    logic [OUT_W-1:0]  col_reg, row_reg;
    logic [SIDE_W-1:0] sx_reg;
    logic [OUT_W-1:0]  accx_reg, accy_reg;
    logic [IDX_W-1:0]  row_base_reg;      // sy * w

    // fetch result metadata, held for the read cycle
    result_t           meta_reg;
    logic              in_range_reg;

    // divider
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den, div_rem;
    logic                 div_done;
    logic [OUT_W-1:0]     small_side;

    // store
    logic [PIX_W-1:0]  rd_pixel;
    logic              store_we, store_re;
    logic [IDX_W-1:0]  idx;
    logic              in_range;

    logic              take, take_store, take_fetch;
    logic              last;
    logic [ACC_W-1:0]  accx_sum, accy_sum;
    logic              cx, cy;
    logic [IDX_W-1:0]  step_prod;

    assign take       = start && !busy;
    assign take_store = take && (request.mode == MODE_STORE);
    assign take_fetch = take && (request.mode == MODE_FETCH);

    // a zero size register counts as 1
    assign w_eff = (src_w_reg == '0) ? SIDE_W'(1) : src_w_reg;
    assign h_eff = (src_h_reg == '0) ? SIDE_W'(1) : src_h_reg;
    assign scale = (w_eff > SIDE_W'(BOX_SIDE)) || (h_eff > SIDE_W'(BOX_SIDE));

    // ---------------------------------------------------------------
    // setup divider operands
    // ---------------------------------------------------------------
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = w_eff;
        case (state_reg)
            ST_SIZE_GO:
            begin
                // shorter side * box / longer side
                div_start = scale;
                if (w_eff >= h_eff)
                begin
                    div_num = DIV_NUM_W'(h_eff) * DIV_NUM_W'(BOX_SIDE);
                    div_den = w_eff;
                end
                else
                begin
                    div_num = DIV_NUM_W'(w_eff) * DIV_NUM_W'(BOX_SIDE);
                    div_den = h_eff;
                end
            end
            ST_COL_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(w_eff);
                div_den   = DIV_DEN_W'(nw_reg);
            end
            ST_ROW_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(h_eff);
                div_den   = DIV_DEN_W'(nh_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    nnbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    // quotient is below 256; at least 1
    assign small_side = (div_quo == '0) ? OUT_W'(1) : div_quo[OUT_W-1:0];
    assign step_prod  = IDX_W'(qh_reg) * IDX_W'(w_eff);

    // ---------------------------------------------------------------
    // fetch walker: source index and next position
    // ---------------------------------------------------------------
    assign idx      = row_base_reg + IDX_W'(sx_reg);
    assign in_range = idx < IDX_W'(STORE_DEPTH);
    assign last     = (col_reg == nw_reg - OUT_W'(1)) && (row_reg == nh_reg - OUT_W'(1));
    assign accx_sum = ACC_W'(accx_reg) + ACC_W'(rw_reg);
    assign accy_sum = ACC_W'(accy_reg) + ACC_W'(rh_reg);
    assign cx       = accx_sum >= ACC_W'(nw_reg);
    assign cy       = accy_sum >= ACC_W'(nh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            src_w_reg     <= SIDE_W'(1);
            src_h_reg     <= SIDE_W'(1);
            nw_reg        <= OUT_W'(1);
            nh_reg        <= OUT_W'(1);
            qw_reg        <= SIDE_W'(1);
            qh_reg        <= SIDE_W'(1);
            rw_reg        <= '0;
            rh_reg        <= '0;
            step_lo_reg   <= IDX_W'(1);
            step_hi_reg   <= IDX_W'(2);
            load_addr_reg <= '0;
            overflow_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            sx_reg        <= '0;
            accx_reg      <= '0;
            accy_reg      <= '0;
            row_base_reg  <= '0;
        end
        else if (wr_en)
        begin
            // register write: restart everything, recompute geometry
            if (wr_index == REG_SOURCE_WIDTH)
            begin
                src_w_reg <= wr_data;
            end
            else if (wr_index == REG_SOURCE_HEIGHT)
            begin
                src_h_reg <= wr_data;
            end
            state_reg     <= ST_SIZE_GO;
            load_addr_reg <= '0;
            overflow_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            sx_reg        <= '0;
            accx_reg      <= '0;
            accy_reg      <= '0;
            row_base_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (take_store)
                    begin
                        if (load_addr_reg < LOAD_W'(STORE_DEPTH))
                        begin
                            load_addr_reg <= load_addr_reg + LOAD_W'(1);
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                    end
                    else if (take_fetch)
                    begin
                        state_reg <= ST_READ;
                        if (col_reg == nw_reg - OUT_W'(1))
                        begin
                            col_reg  <= '0;
                            sx_reg   <= '0;
                            accx_reg <= '0;
                            if (row_reg == nh_reg - OUT_W'(1))
                            begin
                                row_reg      <= '0;
                                accy_reg     <= '0;
                                row_base_reg <= '0;
                            end
                            else
                            begin
                                row_reg      <= row_reg + OUT_W'(1);
                                accy_reg     <= cy ? OUT_W'(accy_sum - ACC_W'(nh_reg))
                                                   : OUT_W'(accy_sum);
                                row_base_reg <= row_base_reg + (cy ? step_hi_reg : step_lo_reg);
                            end
                        end
                        else
                        begin
                            col_reg  <= col_reg + OUT_W'(1);
                            accx_reg <= cx ? OUT_W'(accx_sum - ACC_W'(nw_reg))
                                           : OUT_W'(accx_sum);
                            sx_reg   <= sx_reg + qw_reg + SIDE_W'(cx);
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SIZE_GO:
                begin
                    if (scale)
                    begin
                        state_reg <= ST_SIZE_WAIT;
                    end
                    else
                    begin
                        nw_reg    <= w_eff[OUT_W-1:0];
                        nh_reg    <= h_eff[OUT_W-1:0];
                        state_reg <= ST_COL_GO;
                    end
                end
                ST_SIZE_WAIT:
                begin
                    if (div_done)
                    begin
                        if (w_eff >= h_eff)
                        begin
                            nw_reg <= OUT_W'(BOX_SIDE);
                            nh_reg <= small_side;
                        end
                        else
                        begin
                            nw_reg <= small_side;
                            nh_reg <= OUT_W'(BOX_SIDE);
                        end
                        state_reg <= ST_COL_GO;
                    end
                end
                ST_COL_GO:
                begin
                    state_reg <= ST_COL_WAIT;
                end
                ST_COL_WAIT:
                begin
                    if (div_done)
                    begin
                        qw_reg    <= div_quo[SIDE_W-1:0];
                        rw_reg    <= div_rem[OUT_W-1:0];
                        state_reg <= ST_ROW_GO;
                    end
                end
                ST_ROW_GO:
                begin
                    state_reg <= ST_ROW_WAIT;
                end
                ST_ROW_WAIT:
                begin
                    if (div_done)
                    begin
                        qh_reg    <= div_quo[SIDE_W-1:0];
                        rh_reg    <= div_rem[OUT_W-1:0];
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    step_lo_reg <= step_prod;
                    step_hi_reg <= step_prod + IDX_W'(w_eff);
                    state_reg   <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // fetch metadata captured at the transfer; pixel arrives from the store
    always_ff @(posedge clk)
    begin
        if (take_fetch)
        begin
            meta_reg.out_pixel     <= '0;
            meta_reg.out_col       <= col_reg;
            meta_reg.out_row       <= row_reg;
            meta_reg.out_width     <= nw_reg;
            meta_reg.out_height    <= nh_reg;
            meta_reg.last_pixel    <= last;
            meta_reg.load_overflow <= overflow_reg;
            in_range_reg           <= in_range;
        end
    end

    // ---------------------------------------------------------------
    // pixel store
    // ---------------------------------------------------------------
    assign store_we = take_store && (load_addr_reg < LOAD_W'(STORE_DEPTH));
    assign store_re = take_fetch;

    nnbd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (load_addr_reg[ADDR_W-1:0]),
        .wdata (request.source_pixel),
        .re    (store_re),
        .raddr (idx[ADDR_W-1:0]),
        .rdata (rd_pixel)
    );

    // ---------------------------------------------------------------
    // outputs
    // ---------------------------------------------------------------
    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_READ);

    always_comb
    begin
        result           = meta_reg;
        result.out_pixel = in_range_reg ? rd_pixel : '0;
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_done_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take_fetch && !wr_en))
        else $error("result without a fetch transfer");

    a_fetch_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (take_fetch && !wr_en) |=> done)
        else $error("fetch transfer produced no result");

    a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_col < result.out_width) && (result.out_row < result.out_height))
        else $error("output position outside reduced image");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last_pixel) |-> (col_reg == '0) && (row_reg == '0))
        else $error("walker did not wrap after last pixel");

    a_accum_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (accx_reg < nw_reg) && (accy_reg < nh_reg))
        else $error("error accumulator out of range");

endmodule

`default_nettype wire
